// ===== sv/sdp_pkg.sv =====
// Shared types, widths and codes for the stove damper PID step.
package sdp_pkg;

  // Field and datapath widths
  localparam int TEMP_W     = 11;
  localparam int ERR_W      = 12;
  localparam int DELTA_W    = 13;
  localparam int ESUM_W     = 22;  // signed running integral, before the floor
  localparam int GAIN_W     = 24;
  localparam int LIM_W      = 20;
  localparam int TIME_W     = 32;
  localparam int POS_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 16;  // Q8.16 gains
  localparam int ACC_W      = 49;

  // Damper limits and watchdog rise
  localparam logic [POS_W-1:0]        DAMPER_MIN  = 7'd0;
  localparam logic [POS_W-1:0]        DAMPER_MAX  = 7'd100;
  localparam logic signed [ERR_W-1:0] RISE_NEEDED = 12'sd3;

  // Integral can pass the largest end limit by at most one error step
  localparam logic [ESUM_W-2:0] ERR_SUM_MAX = 21'd1050622;

  typedef enum logic [1:0] {
    ST_MANUAL = 2'd0,
    ST_AUTO   = 2'd1,
    ST_FILL   = 2'd2,
    ST_END    = 2'd3
  } status_e;

  // What the output stage does with the damper position
  typedef enum logic [1:0] {
    DMP_HOLD = 2'd0,
    DMP_MIN  = 2'd1,
    DMP_MAX  = 2'd2,
    DMP_PID  = 2'd3
  } dmp_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET  = 3'd0,
    CFG_MIN     = 3'd1,
    CFG_GAIN_P  = 3'd2,
    CFG_GAIN_I  = 3'd3,
    CFG_GAIN_D  = 3'd4,
    CFG_REFILL  = 3'd5,
    CFG_END     = 3'd6,
    CFG_TIMEOUT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic signed [TEMP_W-1:0] min_temp;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
    logic [LIM_W-1:0]         refill_limit;
    logic [LIM_W-1:0]         end_limit;
    logic [TIME_W-1:0]        low_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [TIME_W-1:0]        now_ms;
    logic                     manual;
    logic                     busy;
  } in_word_t;

  // Decision for one word, carried down the pipeline
  typedef struct packed {
    dmp_op_e op;
    status_e status;
    logic    sleep;
    logic    st_chg;
  } res_t;

  // PID error terms for one word
  typedef struct packed {
    logic signed [ERR_W-1:0]   prop;
    logic signed [ESUM_W-1:0]  sum;
    logic signed [DELTA_W-1:0] delta;
  } pid_err_t;

endpackage

// ===== sv/sdp_ctl.sv =====
// Control stage: PID error state, refuel history, watchdog and status decision.
module sdp_ctl import sdp_pkg::*; #(
  parameter int HISTORY_DEPTH = 10,
  parameter int RECENT_COUNT  = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     ld_i,
  input  in_word_t word_i,
  input  cfg_t     cfg_i,
  output res_t     res_o,
  output pid_err_t err_o
);

  // Window sums and reciprocal for the mean of RECENT_COUNT samples
  localparam int WIN_W = TEMP_W + $clog2(RECENT_COUNT) + 1;
  localparam int DIV_K = WIN_W + 5;
  localparam logic [DIV_K:0] DIV_M =
    (DIV_K+1)'(((1 << DIV_K) + RECENT_COUNT - 1) / RECENT_COUNT);
  localparam int PROD_W = WIN_W + DIV_K + 1;

  // Taps that enter and leave the two windows on a shift
  localparam int  TAP_A  = (RECENT_COUNT < HISTORY_DEPTH) ? RECENT_COUNT - 1
                                                          : HISTORY_DEPTH - 1;
  localparam bit  HAS_B  = (RECENT_COUNT < HISTORY_DEPTH);
  localparam int  TAP_BI = HAS_B ? RECENT_COUNT - 1 : 0;
  localparam int  TAP_BO = !HAS_B ? 0 :
                           ((2 * RECENT_COUNT - 1 < HISTORY_DEPTH) ? 2 * RECENT_COUNT - 1
                                                                   : HISTORY_DEPTH - 1);

  // Mean with truncation toward zero: magnitude times reciprocal
  function automatic logic signed [WIN_W-1:0] win_mean(input logic signed [WIN_W-1:0] x);
    logic [WIN_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [WIN_W-1:0]  fl;
    mag  = x[WIN_W-1] ? WIN_W'(-x) : WIN_W'(x);
    prod = PROD_W'(mag) * PROD_W'(DIV_M);
    fl   = prod[DIV_K +: WIN_W];
    return x[WIN_W-1] ? -$signed(fl) : $signed(fl);
  endfunction

  // State
  logic [ESUM_W-2:0]         err_sum_q, err_sum_d;
  logic signed [ERR_W-1:0]   err_prev_q, err_prev_d;
  logic signed [TEMP_W-1:0]  hist_q [HISTORY_DEPTH];
  logic signed [TEMP_W-1:0]  hist_d [HISTORY_DEPTH];
  logic signed [WIN_W-1:0]   a_sum_q, a_sum_d;
  logic signed [WIN_W-1:0]   b_sum_q, b_sum_d;
  status_e                   status_q, status_d;
  logic                      low_on_q, low_on_d;
  logic [TIME_W-1:0]         low_ms_q, low_ms_d;
  logic signed [TEMP_W-1:0]  low_temp_q, low_temp_d;

  // Stage output
  res_t     res_q;
  pid_err_t err_q;

  logic signed [TEMP_W-1:0]  t, tgt, tmin;
  logic signed [ERR_W-1:0]   err_new, rise, t_ext;
  logic signed [DELTA_W-1:0] delta;
  logic signed [ESUM_W-1:0]  sum_ext, sum_add, sum_pid;
  logic signed [WIN_W-1:0]   a_next, b_next;
  logic [TIME_W-1:0]         elapsed;
  logic                      in_run, refuel, sleep;
  dmp_op_e                   op;

  assign t    = word_i.temp;
  assign tgt  = cfg_i.target_temp;
  assign tmin = cfg_i.min_temp;

  // Error terms
  assign err_new = ERR_W'(tgt) - ERR_W'(t);
  assign delta   = DELTA_W'(err_new) - DELTA_W'(err_prev_q);
  assign sum_ext = $signed({1'b0, err_sum_q});
  assign sum_add = sum_ext + ESUM_W'(err_new);
  assign in_run  = err_sum_q < {1'b0, cfg_i.end_limit};

  // Watchdog comparisons
  assign t_ext   = ERR_W'(t);
  assign rise    = ERR_W'(low_temp_q) + RISE_NEEDED;
  assign elapsed = word_i.now_ms - low_ms_q;

  // Window sums after the new sample shifts in
  assign a_next = a_sum_q + WIN_W'(t) - WIN_W'(hist_q[TAP_A]);
  assign b_next = HAS_B ? b_sum_q + WIN_W'(hist_q[TAP_BI]) - WIN_W'(hist_q[TAP_BO])
                        : '0;
  assign refuel = win_mean(a_next) > win_mean(b_next);

  // Next state and decision
  always_comb begin
    err_sum_d  = err_sum_q;
    err_prev_d = err_prev_q;
    hist_d     = hist_q;
    a_sum_d    = a_sum_q;
    b_sum_d    = b_sum_q;
    status_d   = status_q;
    low_on_d   = low_on_q;
    low_ms_d   = low_ms_q;
    low_temp_d = low_temp_q;
    op         = DMP_HOLD;
    sleep      = 1'b0;
    sum_pid    = sum_ext;

    if (word_i.manual) begin
      status_d = ST_MANUAL;
    end else if (in_run) begin
      if (!low_on_q) begin
        sum_pid    = sum_add;
        err_prev_d = err_new;
      end
      hist_d[0] = t;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_d[i] = hist_q[i-1];
      end
      a_sum_d = a_next;
      b_sum_d = b_next;
      if (refuel) begin
        sum_pid = '0;
      end

      if (t >= tgt) begin
        op       = DMP_MIN;
        status_d = ST_AUTO;
      end else if (t <= tmin) begin
        op       = DMP_MAX;
        status_d = ST_AUTO;
        if (!low_on_q) begin
          low_ms_d   = word_i.now_ms;
          low_temp_d = t;
          low_on_d   = 1'b1;
        end else if (elapsed > cfg_i.low_timeout_ms && t_ext < rise) begin
          op       = DMP_MIN;
          status_d = ST_END;
          sleep    = !word_i.busy;
        end else if (t_ext >= rise) begin
          low_on_d = 1'b0;
        end
      end else if (!low_on_q) begin
        op       = DMP_PID;
        status_d = ST_AUTO;
      end

      // Fill status wins over the status of this word
      if (sum_pid > $signed({2'b0, cfg_i.refill_limit})) begin
        status_d = ST_FILL;
      end
      // Integral floor
      err_sum_d = sum_pid[ESUM_W-1] ? '0 : sum_pid[ESUM_W-2:0];
    end else if (t < tmin) begin
      op       = DMP_MIN;
      status_d = ST_END;
      sleep    = 1'b1;
    end
  end

  // State registers, committed once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      err_prev_q <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      a_sum_q    <= '0;
      b_sum_q    <= '0;
      status_q   <= ST_MANUAL;
      low_on_q   <= 1'b0;
      low_ms_q   <= '0;
      low_temp_q <= '0;
    end else if (ld_i) begin
      err_sum_q  <= err_sum_d;
      err_prev_q <= err_prev_d;
      hist_q     <= hist_d;
      a_sum_q    <= a_sum_d;
      b_sum_q    <= b_sum_d;
      status_q   <= status_d;
      low_on_q   <= low_on_d;
      low_ms_q   <= low_ms_d;
      low_temp_q <= low_temp_d;
    end
  end

  // Stage register toward the multipliers
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q.op     <= op;
      res_q.status <= status_d;
      res_q.sleep  <= sleep;
      res_q.st_chg <= (status_d != status_q);
      err_q.prop   <= err_new;
      err_q.sum    <= sum_pid;
      err_q.delta  <= delta;
    end
  end

  assign res_o = res_q;
  assign err_o = err_q;

`ifndef SYNTHESIS
  // Integral never grows past one step beyond the largest end limit
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_sum_q <= ERR_SUM_MAX)
    else $error("integral out of range");

  // While the watchdog runs the previous error is frozen
  a_prev_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i && low_on_q |=> err_prev_q == $past(err_prev_q))
    else $error("error history moved during watchdog");

  // Manual words leave the integral alone
  a_manual_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i && word_i.manual |=> err_sum_q == $past(err_sum_q))
    else $error("integral moved on a manual word");
`endif

endmodule

// ===== sv/sdp_pid.sv =====
// PID datapath: three gain products, then their sum.
module sdp_pid import sdp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    ld_c_i,
  input  logic                    ld_d_i,
  input  cfg_t                    cfg_i,
  input  res_t                    res_i,
  input  pid_err_t                err_i,
  output res_t                    res_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int PP_W = GAIN_W + 1 + ERR_W;
  localparam int PI_W = GAIN_W + 1 + ESUM_W;
  localparam int PD_W = GAIN_W + 1 + DELTA_W;

  logic signed [PP_W-1:0]  pp_q;
  logic signed [PI_W-1:0]  pi_q;
  logic signed [PD_W-1:0]  pd_q;
  logic signed [ACC_W-1:0] acc_q;
  res_t                    res_c_q, res_d_q;

  // Product stage
  always_ff @(posedge clk_i) begin
    if (ld_c_i) begin
      pp_q    <= $signed({1'b0, cfg_i.gain_p}) * $signed(err_i.prop);
      pi_q    <= $signed({1'b0, cfg_i.gain_i}) * $signed(err_i.sum);
      pd_q    <= $signed({1'b0, cfg_i.gain_d}) * $signed(err_i.delta);
      res_c_q <= res_i;
    end
  end

  // Sum stage
  always_ff @(posedge clk_i) begin
    if (ld_d_i) begin
      acc_q   <= ACC_W'(pp_q) + ACC_W'(pi_q) + ACC_W'(pd_q);
      res_d_q <= res_c_q;
    end
  end

  assign res_o = res_d_q;
  assign acc_o = acc_q;

endmodule

// ===== sv/stove_damper_pid_step.sv =====
// Stove damper PID step: top level with config registers, pipeline and result stage.
//
//   channel  direction  handshake                     payload
//   in       to block   in_valid_i / in_stall_o       temp_now, now_ms, manual_mode, servo_busy
//   out      from block out_valid_o / out_stall_i     damper_percent, status_code, sleep_request,
//                                                     position_changed, status_changed
//   cfg      to block   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// One word per cycle while out_stall_i does not hold the pipeline; a result is valid once its word
// has passed the input reg, control stage, product stage, sum stage and result reg.
// The loop through the integral and history closes inside the control stage.
// Reset loads the default config, clears the PID and history state and sets
// the damper to fully open; no clearing pass. Stalls ripple back stage by stage,
// so empty stages still fill while the result reg waits.
module stove_damper_pid_step import sdp_pkg::*; #(
  parameter int HISTORY_DEPTH = 10,
  parameter int RECENT_COUNT  = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [TEMP_W-1:0] temp_now_i,
  input  logic [TIME_W-1:0]        now_ms_i,
  input  logic                     manual_mode_i,
  input  logic                     servo_busy_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [POS_W-1:0]         damper_percent_o,
  output logic [1:0]               status_code_o,
  output logic                     sleep_request_o,
  output logic                     position_changed_o,
  output logic                     status_changed_o
);

  cfg_t                    cfg_q;
  in_word_t                in_q;
  logic                    a_v_q, b_v_q, c_v_q, d_v_q, out_v_q;
  logic                    rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic                    ld_a, ld_b, ld_c, ld_d, ld_e;
  res_t                    res_b, res_d;
  pid_err_t                err_b;
  logic signed [ACC_W-1:0] acc_d;
  logic [ACC_W-FRAC_W-1:0] whole;
  logic [POS_W-1:0]        pid_pos, pos_d;
  logic [POS_W-1:0]        damper_q;
  status_e                 status_q;
  logic                    sleep_q, pos_chg_q, st_chg_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp    <= 11'sd200;
      cfg_q.min_temp       <= 11'sd50;
      cfg_q.gain_p         <= 24'd1638400;
      cfg_q.gain_i         <= 24'd1638;
      cfg_q.gain_d         <= 24'd327680;
      cfg_q.refill_limit   <= 20'd5000;
      cfg_q.end_limit      <= 20'd10000;
      cfg_q.low_timeout_ms <= 32'd240000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET:  cfg_q.target_temp    <= cfg_data_i[TEMP_W-1:0];
        CFG_MIN:     cfg_q.min_temp       <= cfg_data_i[TEMP_W-1:0];
        CFG_GAIN_P:  cfg_q.gain_p         <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:  cfg_q.gain_i         <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:  cfg_q.gain_d         <= cfg_data_i[GAIN_W-1:0];
        CFG_REFILL:  cfg_q.refill_limit   <= cfg_data_i[LIM_W-1:0];
        CFG_END:     cfg_q.end_limit      <= cfg_data_i[LIM_W-1:0];
        CFG_TIMEOUT: cfg_q.low_timeout_ms <= cfg_data_i[TIME_W-1:0];
      endcase
    end
  end

  // Per-stage ready and load
  assign rdy_e = !out_v_q || !out_stall_i;
  assign rdy_d = !d_v_q || rdy_e;
  assign rdy_c = !c_v_q || rdy_d;
  assign rdy_b = !b_v_q || rdy_c;
  assign rdy_a = !a_v_q || rdy_b;

  assign ld_a = in_valid_i && rdy_a;
  assign ld_b = a_v_q && rdy_b;
  assign ld_c = b_v_q && rdy_c;
  assign ld_d = c_v_q && rdy_d;
  assign ld_e = d_v_q && rdy_e;

  assign in_stall_o = !rdy_a;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy_a) a_v_q   <= ld_a;
      if (rdy_b) b_v_q   <= ld_b;
      if (rdy_c) c_v_q   <= ld_c;
      if (rdy_d) d_v_q   <= ld_d;
      if (rdy_e) out_v_q <= ld_e;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      in_q.temp   <= temp_now_i;
      in_q.now_ms <= now_ms_i;
      in_q.manual <= manual_mode_i;
      in_q.busy   <= servo_busy_i;
    end
  end

  sdp_ctl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .RECENT_COUNT  (RECENT_COUNT)
  ) u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld_b),
    .word_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res_b),
    .err_o  (err_b)
  );

  sdp_pid u_pid (
    .clk_i  (clk_i),
    .ld_c_i (ld_c),
    .ld_d_i (ld_d),
    .cfg_i  (cfg_q),
    .res_i  (res_b),
    .err_i  (err_b),
    .res_o  (res_d),
    .acc_o  (acc_d)
  );

  // Truncate PID output and clamp to the damper range
  assign whole   = acc_d[ACC_W-1:FRAC_W];
  assign pid_pos = acc_d[ACC_W-1] ? DAMPER_MIN :
                   (whole > (ACC_W-FRAC_W)'(DAMPER_MAX)) ? DAMPER_MAX : whole[POS_W-1:0];

  always_comb begin
    unique case (res_d.op)
      DMP_HOLD: pos_d = damper_q;
      DMP_MIN:  pos_d = DAMPER_MIN;
      DMP_MAX:  pos_d = DAMPER_MAX;
      DMP_PID:  pos_d = pid_pos;
    endcase
  end

  // Result register; damper position doubles as state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damper_q <= DAMPER_MAX;
    end else if (ld_e) begin
      damper_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_e) begin
      status_q  <= res_d.status;
      sleep_q   <= res_d.sleep;
      pos_chg_q <= (pos_d != damper_q);
      st_chg_q  <= res_d.st_chg;
    end
  end

  assign out_valid_o        = out_v_q;
  assign damper_percent_o   = damper_q;
  assign status_code_o      = status_q;
  assign sleep_request_o    = sleep_q;
  assign position_changed_o = pos_chg_q;
  assign status_changed_o   = st_chg_q;

`ifndef SYNTHESIS
  // Damper stays inside its range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> damper_percent_o <= DAMPER_MAX)
    else $error("damper out of range");

  // Sleep only comes with a closed damper; fill status may mask the end status
  a_sleep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sleep_request_o |-> damper_percent_o == DAMPER_MIN)
    else $error("sleep with damper open");

  // Position flag matches the move of the held position
  a_pos_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_e |=> position_changed_o == (damper_q != $past(damper_q)))
    else $error("position flag mismatch");
`endif

endmodule
